// File: sv/prrs_pkg.sv
// Package for the priority round-robin scheduler.
// Holds field widths, command/status codes and the control types.
// No dependencies.
package prrs_pkg;

    localparam int CMD_W    = 3;
    localparam int PRIO_W   = 3;
    localparam int EVENT_W  = 8;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 5;
    localparam int RID_W    = 4;
    localparam int QUANT_W  = 16;
    localparam int EVCNT_W  = 9;
    localparam int STAMP_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EV_COUNT = 1'd1;

    localparam logic [CMD_W-1:0] CMD_FORK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WAIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SIGNAL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINISH = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_FREE    = 3'd0,
        ST_READY   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_WAITING = 3'd3,
        ST_DONE    = 3'd4
    } slot_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_EXEC,
        C_SCAN,
        C_WAKE,
        C_TICK,
        C_DISP,
        C_OUT
    } ctrl_state_t;

    // What follows a table scan
    typedef enum logic [1:0] {
        FOL_DONE,
        FOL_TICK,
        FOL_DISPATCH,
        FOL_WAKE
    } follow_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LATCH,
        DP_EXEC,
        DP_SCAN,
        DP_WAKE,
        DP_TICK,
        DP_DISPATCH,
        DP_OUTPUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   scan_clr;
        logic   wait_mode;
    } dp_cmd_t;

    typedef struct packed {
        follow_t follow;
        logic    scan_last;
        logic    best_valid;
        logic    cur_valid;
    } dp_status_t;

endpackage

// File: sv/prrs_if.sv
// Channel interfaces of the scheduler: command, result and configuration.
// Depends on prrs_pkg.
interface prrs_in_if import prrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [PRIO_W-1:0]   priority_req;
    logic [EVENT_W-1:0]  event_req;

    modport source (output valid, cmd, priority_req, event_req, input ready);
    modport sink   (input valid, cmd, priority_req, event_req, output ready);
endinterface

interface prrs_out_if import prrs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
    logic                running_valid;
    logic [RID_W-1:0]    running_id;

    modport source (output valid, status, value, running_valid, running_id, input ready);
    modport sink   (input valid, status, value, running_valid, running_id, output ready);
endinterface

interface prrs_cfg_if import prrs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/prrs_ctrl.sv
// Sequencer of the scheduler: command decode phases, table scans, result hand-off.
// Depends on prrs_pkg; drives prrs_datapath through dp_cmd_t.
module prrs_ctrl import prrs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t dp_sts,
    output dp_cmd_t    dp_cmd
);

    ctrl_state_t state_reg, state_next;
    follow_t     follow_reg, follow_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_IDLE;
            follow_reg    <= FOL_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            follow_reg    <= follow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        follow_next = follow_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                    state_next = C_EXEC;
            end
            C_EXEC:
            begin
                follow_next = dp_sts.follow;
                state_next  = (dp_sts.follow == FOL_DONE) ? C_OUT : C_SCAN;
            end
            C_SCAN:
            begin
                if (dp_sts.scan_last)
                begin
                    unique case (follow_reg)
                        FOL_WAKE:     state_next = C_WAKE;
                        FOL_TICK:     state_next = C_TICK;
                        FOL_DISPATCH: state_next = C_DISP;
                        default:      state_next = C_OUT;
                    endcase
                end
            end
            C_WAKE:
            begin
                state_next = C_SCAN;
                if (dp_sts.best_valid)
                    follow_next = FOL_WAKE;
                else if (dp_sts.cur_valid)
                    follow_next = FOL_TICK;
                else
                    follow_next = FOL_DISPATCH;
            end
            C_TICK:  state_next = C_OUT;
            C_DISP:  state_next = C_OUT;
            C_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        dp_cmd.op        = DP_NOP;
        dp_cmd.scan_clr  = 1'b0;
        dp_cmd.wait_mode = (follow_reg == FOL_WAKE);
        in_ready         = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    dp_cmd.op = DP_LATCH;
            end
            C_EXEC:
            begin
                dp_cmd.op       = DP_EXEC;
                dp_cmd.scan_clr = 1'b1;
            end
            C_SCAN:  dp_cmd.op = DP_SCAN;
            C_WAKE:
            begin
                dp_cmd.op       = DP_WAKE;
                dp_cmd.scan_clr = 1'b1;
            end
            C_TICK:  dp_cmd.op = DP_TICK;
            C_DISP:  dp_cmd.op = DP_DISPATCH;
            C_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.op = DP_OUTPUT;
                    out_load  = 1'b1;
                end
            end
            default: dp_cmd.op = DP_NOP;
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/prrs_datapath.sv
// Datapath of the scheduler: thread table, running-thread registers, scan unit,
// configuration registers and result registers. Depends on prrs_pkg.
module prrs_datapath import prrs_pkg::*; #(
    parameter int MAX_THREADS  = 16,
    parameter int MAX_PRIORITY = 5,
    parameter int MAX_EVENTS   = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            dp_sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [PRIO_W-1:0]     priority_req,
    input  logic [EVENT_W-1:0]    event_req,
    output logic [STATUS_W-1:0]   status,
    output logic [VALUE_W-1:0]    value,
    output logic                  running_valid,
    output logic [RID_W-1:0]      running_id
);

    localparam int SW = $clog2(MAX_THREADS);
    localparam int UW = $clog2(MAX_THREADS + 1);
    localparam logic [EVCNT_W-1:0] EV_MAX   = EVCNT_W'(MAX_EVENTS);
    localparam logic [PRIO_W-1:0]  PRIO_MAX = PRIO_W'(MAX_PRIORITY);
    localparam logic [UW-1:0]      N_SLOTS  = UW'(MAX_THREADS);
    localparam logic [SW-1:0]      LAST_IDX = SW'(MAX_THREADS - 1);

    // configuration
    logic [QUANT_W-1:0] quantum_reg;
    logic [EVCNT_W-1:0] ev_count_reg;

    // thread table
    slot_state_t        st_reg    [MAX_THREADS];
    logic [PRIO_W-1:0]  prio_reg  [MAX_THREADS];
    logic [EVENT_W-1:0] evt_reg   [MAX_THREADS];
    logic [STAMP_W-1:0] stamp_reg [MAX_THREADS];

    logic [STAMP_W-1:0] order_reg;
    logic [UW-1:0]      used_reg;
    logic [SW-1:0]      cur_reg;
    logic               cur_valid_reg;
    logic [PRIO_W-1:0]  cur_prio_reg;
    logic [QUANT_W-1:0] ticks_reg;

    // latched command
    logic [CMD_W-1:0]   cmd_reg;
    logic [PRIO_W-1:0]  rprio_reg;
    logic [EVENT_W-1:0] rev_reg;

    // scan unit
    logic [SW-1:0]      scan_idx_reg;
    logic               best_valid_reg;
    logic [SW-1:0]      best_idx_reg;
    logic [PRIO_W-1:0]  best_prio_reg;
    logic [STAMP_W-1:0] best_age_reg;

    logic [STATUS_W-1:0] sts_reg;
    logic [UW-1:0]       val_reg;

    logic [STATUS_W-1:0] out_status_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_rv_reg;
    logic [RID_W-1:0]    out_rid_reg;

    logic [QUANT_W-1:0] qval;
    logic [EVCNT_W-1:0] ev_lim;
    logic               ev_bad;
    logic [SW-1:0]      s_new;
    logic is_fork, is_tick, is_wait, is_sig, is_fin;
    logic fork_badp, fork_full, fork_ok, fork_run, fork_pre, fork_q;
    logic wait_ok, sig_ok, fin_ok;
    logic [STATUS_W-1:0] exec_status;
    follow_t             exec_follow;

    logic               cand, better;
    logic [STAMP_W-1:0] age;

    logic [QUANT_W-1:0] t_dec;
    logic               tick_switch;

    // table write controls
    logic               sa_we, sb_we;
    logic [SW-1:0]      sa_idx, sb_idx;
    slot_state_t        sa_val, sb_val;
    logic               stamp_we;
    logic [SW-1:0]      stamp_idx;
    logic               run_we;
    logic [SW-1:0]      run_idx;
    logic [PRIO_W-1:0]  run_prio;
    logic               idle_we;
    logic               ticks_we;
    logic [QUANT_W-1:0] ticks_val;

    assign qval   = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
    assign ev_lim = (ev_count_reg > EV_MAX) ? EV_MAX : ev_count_reg;
    assign ev_bad = {1'b0, rev_reg} >= ev_lim;
    assign s_new  = used_reg[SW-1:0];

    assign is_fork = (cmd_reg == CMD_FORK);
    assign is_tick = (cmd_reg == CMD_TICK);
    assign is_wait = (cmd_reg == CMD_WAIT);
    assign is_sig  = (cmd_reg == CMD_SIGNAL);
    assign is_fin  = (cmd_reg == CMD_FINISH);

    assign fork_badp = rprio_reg > PRIO_MAX;
    assign fork_full = used_reg >= N_SLOTS;
    assign fork_ok   = is_fork && !fork_badp && !fork_full;
    assign fork_run  = fork_ok && !cur_valid_reg;
    assign fork_pre  = fork_ok && cur_valid_reg && (rprio_reg > cur_prio_reg);
    assign fork_q    = fork_ok && cur_valid_reg && !(rprio_reg > cur_prio_reg);
    assign wait_ok   = is_wait && !ev_bad && cur_valid_reg;
    assign sig_ok    = is_sig && !ev_bad;
    assign fin_ok    = is_fin && cur_valid_reg;

    always_comb
    begin
        priority if (is_fork)
            exec_status = fork_badp ? STS_BAD : (fork_full ? STS_FULL : STS_OK);
        else if (is_tick)
            exec_status = STS_OK;
        else if (is_wait)
            exec_status = wait_ok ? STS_OK : STS_BAD;
        else if (is_sig)
            exec_status = sig_ok ? STS_OK : STS_BAD;
        else if (is_fin)
            exec_status = fin_ok ? STS_OK : STS_BAD;
        else
            exec_status = STS_BAD;
    end

    always_comb
    begin
        priority if (fork_q || (is_tick && cur_valid_reg))
            exec_follow = FOL_TICK;
        else if (wait_ok || fin_ok)
            exec_follow = FOL_DISPATCH;
        else if (sig_ok)
            exec_follow = FOL_WAKE;
        else
            exec_follow = FOL_DONE;
    end

    // one table entry per scan cycle
    assign age = order_reg - stamp_reg[scan_idx_reg];
    assign cand = dp_cmd.wait_mode
                ? (st_reg[scan_idx_reg] == ST_WAITING && evt_reg[scan_idx_reg] == rev_reg)
                : (st_reg[scan_idx_reg] == ST_READY);
    assign better = !best_valid_reg
                 || (!dp_cmd.wait_mode && prio_reg[scan_idx_reg] > best_prio_reg)
                 || ((dp_cmd.wait_mode || prio_reg[scan_idx_reg] == best_prio_reg)
                     && age > best_age_reg);

    // quantum accounting for the running thread
    assign t_dec = (ticks_reg != '0) ? ticks_reg - 1'b1 : ticks_reg;
    always_comb
    begin
        if (t_dec == '0)
            tick_switch = best_valid_reg && !(best_prio_reg < cur_prio_reg);
        else
            tick_switch = best_valid_reg && (best_prio_reg > cur_prio_reg);
    end

    always_comb
    begin
        sa_we     = 1'b0;
        sa_idx    = cur_reg;
        sa_val    = ST_READY;
        sb_we     = 1'b0;
        sb_idx    = s_new;
        sb_val    = ST_RUNNING;
        stamp_we  = 1'b0;
        stamp_idx = cur_reg;
        run_we    = 1'b0;
        run_idx   = s_new;
        run_prio  = rprio_reg;
        idle_we   = 1'b0;
        ticks_we  = 1'b0;
        ticks_val = qval;
        unique case (dp_cmd.op)
            DP_EXEC:
            begin
                if (fork_run)
                begin
                    sb_we  = 1'b1;
                    run_we = 1'b1;
                end
                if (fork_pre)
                begin
                    sa_we    = 1'b1;
                    stamp_we = 1'b1;
                    sb_we    = 1'b1;
                    run_we   = 1'b1;
                end
                if (fork_q)
                begin
                    sb_we     = 1'b1;
                    sb_val    = ST_READY;
                    stamp_we  = 1'b1;
                    stamp_idx = s_new;
                end
                if (wait_ok)
                begin
                    sa_we    = 1'b1;
                    sa_val   = ST_WAITING;
                    stamp_we = 1'b1;
                    idle_we  = 1'b1;
                end
                if (fin_ok)
                begin
                    sa_we   = 1'b1;
                    sa_val  = ST_DONE;
                    idle_we = 1'b1;
                end
            end
            DP_WAKE:
            begin
                if (best_valid_reg)
                begin
                    sb_we     = 1'b1;
                    sb_idx    = best_idx_reg;
                    sb_val    = ST_READY;
                    stamp_we  = 1'b1;
                    stamp_idx = best_idx_reg;
                end
            end
            DP_TICK:
            begin
                if (tick_switch)
                begin
                    sa_we    = 1'b1;
                    stamp_we = 1'b1;
                    sb_we    = 1'b1;
                    sb_idx   = best_idx_reg;
                    run_we   = 1'b1;
                    run_idx  = best_idx_reg;
                    run_prio = best_prio_reg;
                end
                else
                begin
                    ticks_we  = 1'b1;
                    ticks_val = (t_dec == '0) ? qval : t_dec;
                end
            end
            DP_DISPATCH:
            begin
                if (best_valid_reg)
                begin
                    sb_we    = 1'b1;
                    sb_idx   = best_idx_reg;
                    run_we   = 1'b1;
                    run_idx  = best_idx_reg;
                    run_prio = best_prio_reg;
                end
            end
            default:
            begin
                sa_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
                st_reg[i] <= ST_FREE;
            quantum_reg    <= QUANT_W'(1);
            ev_count_reg   <= '0;
            order_reg      <= '0;
            used_reg       <= '0;
            cur_reg        <= '0;
            cur_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_QUANTUM)
                quantum_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_EV_COUNT)
                ev_count_reg <= cfg_data[EVCNT_W-1:0];
            if (sa_we)
                st_reg[sa_idx] <= sa_val;
            if (sb_we)
                st_reg[sb_idx] <= sb_val;
            if (stamp_we)
                order_reg <= order_reg + 1'b1;
            if (dp_cmd.op == DP_EXEC && fork_ok)
                used_reg <= used_reg + 1'b1;
            if (run_we)
            begin
                cur_reg       <= run_idx;
                cur_valid_reg <= 1'b1;
            end
            else if (idle_we)
            begin
                cur_reg       <= '0;
                cur_valid_reg <= 1'b0;
            end
            if (dp_cmd.scan_clr)
            begin
                scan_idx_reg   <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (dp_cmd.op == DP_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (cand && better)
                    best_valid_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == DP_LATCH)
        begin
            cmd_reg   <= cmd;
            rprio_reg <= priority_req;
            rev_reg   <= event_req;
        end
        if (dp_cmd.op == DP_EXEC)
        begin
            sts_reg <= exec_status;
            val_reg <= fork_ok ? UW'(s_new) : '0;
        end
        else if (dp_cmd.op == DP_WAKE && best_valid_reg)
            val_reg <= val_reg + 1'b1;
        if (dp_cmd.op == DP_EXEC && fork_ok)
        begin
            prio_reg[s_new] <= rprio_reg;
            evt_reg[s_new]  <= '0;
        end
        if (dp_cmd.op == DP_EXEC && wait_ok)
            evt_reg[cur_reg] <= rev_reg;
        if (stamp_we)
            stamp_reg[stamp_idx] <= order_reg;
        if (run_we)
        begin
            cur_prio_reg <= run_prio;
            ticks_reg    <= qval;
        end
        else if (ticks_we)
            ticks_reg <= ticks_val;
        if (dp_cmd.op == DP_SCAN && cand && better)
        begin
            best_idx_reg  <= scan_idx_reg;
            best_prio_reg <= prio_reg[scan_idx_reg];
            best_age_reg  <= age;
        end
        if (dp_cmd.op == DP_OUTPUT)
        begin
            out_status_reg <= sts_reg;
            out_value_reg  <= VALUE_W'(val_reg);
            out_rv_reg     <= cur_valid_reg;
            out_rid_reg    <= cur_valid_reg ? RID_W'(cur_reg) : '0;
        end
    end

    assign dp_sts.follow     = exec_follow;
    assign dp_sts.scan_last  = (scan_idx_reg == LAST_IDX);
    assign dp_sts.best_valid = best_valid_reg;
    assign dp_sts.cur_valid  = cur_valid_reg;

    assign status        = out_status_reg;
    assign value         = out_value_reg;
    assign running_valid = out_rv_reg;
    assign running_id    = out_rid_reg;

endmodule

// File: sv/priority_round_robin_scheduler.sv
// Priority preemptive round-robin scheduler, top level.
// Depends on prrs_pkg, the channel interfaces, prrs_ctrl and prrs_datapath.
//
// One command is handled at a time and gives one result. Commands that need no
// table search (bad arguments, fork into an idle or preempted processor, tick
// while idle) go from transfer to result without a scan. A tick, a fork that queues,
// a wait or a finish adds one linear scan of the thread table, one slot per
// cycle. A signal that wakes k threads runs k + 2 scans. The next command is
// taken while a result waits in the output register. Configuration writes are
// taken in any cycle.
module priority_round_robin_scheduler import prrs_pkg::*; #(
    parameter int MAX_THREADS  = 16,
    parameter int MAX_PRIORITY = 5,
    parameter int MAX_EVENTS   = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    prrs_in_if.sink   cmd_ch,
    prrs_out_if.source result_ch,
    prrs_cfg_if.sink  cfg_ch
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_sts;

    assign cfg_ch.ready = 1'b1;

    prrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .in_ready  (cmd_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .dp_sts    (dp_sts),
        .dp_cmd    (dp_cmd)
    );

    prrs_datapath #(
        .MAX_THREADS  (MAX_THREADS),
        .MAX_PRIORITY (MAX_PRIORITY),
        .MAX_EVENTS   (MAX_EVENTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_sts        (dp_sts),
        .cfg_we        (cfg_ch.valid),
        .cfg_index     (cfg_ch.index),
        .cfg_data      (cfg_ch.data),
        .cmd           (cmd_ch.cmd),
        .priority_req  (cmd_ch.priority_req),
        .event_req     (cmd_ch.event_req),
        .status        (result_ch.status),
        .value         (result_ch.value),
        .running_valid (result_ch.running_valid),
        .running_id    (result_ch.running_id)
    );

endmodule

// File: sv/prrs_checker.sv
// Port-level checks on the scheduler's result channel, bound to the top level.
// Depends on prrs_pkg and priority_round_robin_scheduler.
module prrs_checker import prrs_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [VALUE_W-1:0]  value,
    input logic                running_valid,
    input logic [RID_W-1:0]    running_id
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value)
            && $stable(running_valid) && $stable(running_id))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STS_OK || status == STS_BAD || status == STS_FULL))
        else $error("undefined status code");

    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> value == '0)
        else $error("nonzero value on error");

    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running_valid |-> running_id == '0)
        else $error("running id set while idle");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .status        (result_ch.status),
    .value         (result_ch.value),
    .running_valid (result_ch.running_valid),
    .running_id    (result_ch.running_id)
);

// File: bench/tb.sv
// Testbench for the priority round-robin scheduler: directed table, then random commands.
// Expected results come from a behavioral model of the thread table kept here.
// Depends on prrs_pkg, prrs_if and priority_round_robin_scheduler.
module tb import prrs_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTHR = 16;
    localparam int MAXP = 5;
    localparam int MAXEV = 256;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic                rv;
        logic [RID_W-1:0]    rid;
    } sched_res_t;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [PRIO_W-1:0]  prio;
        logic [EVENT_W-1:0] ev;
        bit                 has_exp;
        sched_res_t         exp;
    } stim_row_t;

    logic clk = 0;
    logic rst_n = 0;

    prrs_in_if  cmd_ch ();
    prrs_out_if result_ch ();
    prrs_cfg_if cfg_ch ();

    priority_round_robin_scheduler u_top (
        .clk(clk), .rst_n(rst_n), .cmd_ch(cmd_ch), .result_ch(result_ch), .cfg_ch(cfg_ch)
    );

    // scheduler shadow state
    logic [15:0] q_ticks;
    logic [8:0]  ev_cnt;
    slot_state_t th_state [NTHR];
    logic [2:0]  th_prio [NTHR];
    logic [15:0] th_left [NTHR];
    logic [7:0]  th_ev [NTHR];
    logic [31:0] th_stamp [NTHR];
    logic [31:0] order_ctr;
    int          used_cnt;
    int          cur_id;
    bit          cur_on;

    sched_res_t  expected_q[$];
    int          mismatches = 0;
    bit          tail_mode = 0;
    bit          sink_free = 0;

    function automatic logic [15:0] quantum();
        return (q_ticks == 0) ? 16'd1 : q_ticks;
    endfunction

    function automatic int ev_limit();
        return (ev_cnt > MAXEV) ? MAXEV : int'(ev_cnt);
    endfunction

    function automatic void mark_ready(int s);
        th_state[s] = ST_READY;
        th_stamp[s] = order_ctr;
        order_ctr++;
    endfunction

    function automatic void dispatch(int s);
        th_state[s] = ST_RUNNING;
        th_left[s] = quantum();
        cur_id = s;
        cur_on = 1;
    endfunction

    function automatic int best_ready();
        int b;
        logic [31:0] ba, a;
        b = -1;
        ba = 0;
        for (int i = 0; i < NTHR; i++)
        begin
            if (th_state[i] != ST_READY) continue;
            a = order_ctr - th_stamp[i];
            if (b < 0 || th_prio[i] > th_prio[b] || (th_prio[i] == th_prio[b] && a > ba))
            begin
                b = i;
                ba = a;
            end
        end
        return b;
    endfunction

    function automatic void tick_running();
        int c, n;
        logic [15:0] t;
        if (!cur_on) return;
        c = cur_id;
        t = th_left[c];
        if (t > 0) t--;
        th_left[c] = t;
        n = best_ready();
        if (t == 0)
        begin
            if (n < 0 || th_prio[n] < th_prio[c])
            begin
                th_left[c] = quantum();
                return;
            end
            mark_ready(c);
            dispatch(n);
        end
        else if (n >= 0 && th_prio[n] > th_prio[c])
        begin
            th_left[c] = quantum();
            mark_ready(c);
            dispatch(n);
        end
    endfunction

    function automatic sched_res_t predict_cmd(logic [2:0] cmd, logic [2:0] pr,
                                               logic [7:0] ev);
        sched_res_t r;
        int s, n, b, cnt;
        logic [31:0] ba, a;
        r = '0;
        case (cmd)
            CMD_FORK:
            begin
                if (pr > MAXP) r.status = STS_BAD;
                else if (used_cnt >= NTHR) r.status = STS_FULL;
                else
                begin
                    s = used_cnt++;
                    r.value = VALUE_W'(s);
                    th_prio[s] = pr;
                    th_ev[s] = 0;
                    th_left[s] = quantum();
                    if (!cur_on) dispatch(s);
                    else if (pr > th_prio[cur_id])
                    begin
                        th_left[cur_id] = quantum();
                        mark_ready(cur_id);
                        dispatch(s);
                    end
                    else
                    begin
                        mark_ready(s);
                        tick_running();
                    end
                end
            end
            CMD_TICK: tick_running();
            CMD_WAIT:
            begin
                if (ev >= ev_limit() || !cur_on) r.status = STS_BAD;
                else
                begin
                    th_state[cur_id] = ST_WAITING;
                    th_ev[cur_id] = ev;
                    th_stamp[cur_id] = order_ctr;
                    order_ctr++;
                    cur_on = 0;
                    cur_id = 0;
                    n = best_ready();
                    if (n >= 0) dispatch(n);
                end
            end
            CMD_SIGNAL:
            begin
                if (ev >= ev_limit()) r.status = STS_BAD;
                else
                begin
                    cnt = 0;
                    forever
                    begin
                        b = -1;
                        ba = 0;
                        for (int i = 0; i < NTHR; i++)
                        begin
                            if (th_state[i] != ST_WAITING || th_ev[i] != ev) continue;
                            a = order_ctr - th_stamp[i];
                            if (b < 0 || a > ba)
                            begin
                                b = i;
                                ba = a;
                            end
                        end
                        if (b < 0) break;
                        mark_ready(b);
                        cnt++;
                    end
                    r.value = VALUE_W'(cnt);
                    if (cur_on) tick_running();
                    else
                    begin
                        n = best_ready();
                        if (n >= 0) dispatch(n);
                    end
                end
            end
            CMD_FINISH:
            begin
                if (!cur_on) r.status = STS_BAD;
                else
                begin
                    th_state[cur_id] = ST_DONE;
                    cur_on = 0;
                    cur_id = 0;
                    n = best_ready();
                    if (n >= 0) dispatch(n);
                end
            end
            default: r.status = STS_BAD;
        endcase
        r.rv = cur_on;
        r.rid = cur_on ? cur_id[3:0] : 4'd0;
        return r;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NTHR; i++) th_state[i] = ST_FREE;
        order_ctr = 0;
        used_cnt = 0;
        cur_id = 0;
        cur_on = 0;
    endfunction

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("CHECK FAILED");
        $finish;
    end

    // idle source; valid drops for a random gap here, and also in drain
    task automatic src_gap();
        if (!tail_mode && $urandom_range(0, 7) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    task automatic send_cmd(logic [2:0] c, logic [2:0] p, logic [7:0] e, bit chk,
                            sched_res_t ex);
        sched_res_t pr;
        src_gap();
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= c;
        cmd_ch.priority_req <= p;
        cmd_ch.event_req <= e;
        do @(posedge clk); while (!cmd_ch.ready);
        pr = predict_cmd(c, p, e);
        if (chk && pr != ex)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with model: row %h model %h", ex, pr);
        end
        expected_q.push_back(pr);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == CFG_QUANTUM) q_ticks = d;
        else ev_cnt = d[8:0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // result checker
    initial
    begin
        sched_res_t got, ex;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{result_ch.status, result_ch.value, result_ch.running_valid,
                        result_ch.running_id};
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end
                else
                begin
                    ex = expected_q.pop_front();
                    if (got != ex)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                ex.status, ex.value, ex.rv, ex.rid,
                                got.status, got.value, got.rv, got.rid);
                    end
                end
            end
        end
    end

    // sink idling
    initial
    begin
        result_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (!tail_mode && $urandom_range(0, 9) == 0)
            begin
                result_ch.ready <= 0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            result_ch.ready <= 1;
        end
    end

    task automatic random_phase(int n, bit good);
        logic [2:0] c, p;
        logic [7:0] e;
        int lim;
        for (int k = 0; k < n; k++)
        begin
            lim = ev_limit();
            if (good)
            begin
                case ($urandom_range(0, 9))
                    0, 1: c = CMD_FORK;
                    2, 3, 4: c = CMD_TICK;
                    5, 6: c = CMD_WAIT;
                    7, 8: c = CMD_SIGNAL;
                    default: c = CMD_FINISH;
                endcase
                if ($urandom_range(0, 6) == 0)
                    p = 3'($urandom_range(0, 7));
                else
                    p = 3'($urandom_range(0, MAXP));
                if (lim > 0 && $urandom_range(0, 9) != 0)
                    e = 8'($urandom_range(0, (lim > 4 ? 3 : lim - 1)));
                else
                    e = 8'($urandom);
            end
            else
            begin
                c = 3'($urandom);
                p = 3'($urandom);
                e = 8'($urandom);
            end
            send_cmd(c, p, e, 0, '0);
        end
    endtask

    stim_row_t dir_rows[$];

    function automatic stim_row_t row(logic [2:0] c, logic [2:0] p, logic [7:0] e, bit h,
                                      sched_res_t x);
        stim_row_t r;
        r.cmd = c; r.prio = p; r.ev = e; r.has_exp = h; r.exp = x;
        return r;
    endfunction

    initial
    begin
        cmd_ch.valid = 0;
        cmd_ch.cmd = CMD_TICK;
        cmd_ch.priority_req = 0;
        cmd_ch.event_req = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = CFG_QUANTUM;
        cfg_ch.data = 0;
        q_ticks = 1;
        ev_cnt = 0;
        clear_table();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // after reset: idle checks, bad codes and priorities, then a first fork
        dir_rows.push_back(row(CMD_TICK, 0, 0, 1, '{STS_OK, 0, 0, 0}));
        dir_rows.push_back(row(CMD_FINISH, 0, 0, 1, '{STS_BAD, 0, 0, 0}));
        dir_rows.push_back(row(CMD_WAIT, 0, 0, 1, '{STS_BAD, 0, 0, 0}));
        dir_rows.push_back(row(CMD_SIGNAL, 0, 0, 1, '{STS_BAD, 0, 0, 0}));
        dir_rows.push_back(row(3'd5, 0, 0, 1, '{STS_BAD, 0, 0, 0}));
        dir_rows.push_back(row(3'd7, 7, 255, 1, '{STS_BAD, 0, 0, 0}));
        dir_rows.push_back(row(CMD_FORK, 7, 0, 1, '{STS_BAD, 0, 0, 0}));
        dir_rows.push_back(row(CMD_FORK, 6, 0, 1, '{STS_BAD, 0, 0, 0}));
        dir_rows.push_back(row(CMD_FORK, 0, 0, 1, '{STS_OK, 0, 1, 0}));
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].prio, dir_rows[i].ev,
                     dir_rows[i].has_exp, dir_rows[i].exp);
        dir_rows.delete();
        drain();

        write_reg(CFG_EV_COUNT, 16'h01FF);
        write_reg(CFG_QUANTUM, 16'd0);
        dir_rows.push_back(row(CMD_FORK, 5, 0, 1, '{STS_OK, 1, 1, 1}));
        dir_rows.push_back(row(CMD_FORK, 3, 0, 0, '0));
        dir_rows.push_back(row(CMD_TICK, 0, 0, 0, '0));
        dir_rows.push_back(row(CMD_WAIT, 0, 255, 0, '0));
        dir_rows.push_back(row(CMD_WAIT, 0, 255, 0, '0));
        dir_rows.push_back(row(CMD_SIGNAL, 0, 255, 0, '0));
        dir_rows.push_back(row(CMD_SIGNAL, 0, 7, 0, '0));
        dir_rows.push_back(row(CMD_FINISH, 0, 0, 0, '0));
        dir_rows.push_back(row(CMD_FINISH, 0, 0, 0, '0));
        dir_rows.push_back(row(CMD_FINISH, 0, 0, 0, '0));
        for (int i = 0; i < 13; i++) dir_rows.push_back(row(CMD_FORK, 3'(i % 6), 0, 0, '0));
        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].prio, dir_rows[i].ev,
                     dir_rows[i].has_exp, dir_rows[i].exp);
        drain();

        // random phases; the table holds all 16 slots by now and is never cleared, so
        // no fork in these phases takes a new slot
        write_reg(CFG_QUANTUM, 16'd3);
        write_reg(CFG_EV_COUNT, 16'd4);
        random_phase(400, 1);
        drain();
        write_reg(CFG_QUANTUM, 16'hFFFF);
        write_reg(CFG_EV_COUNT, 16'd256);
        random_phase(300, 1);
        random_phase(100, 0);
        drain();
        write_reg(CFG_QUANTUM, 16'd1);
        write_reg(CFG_EV_COUNT, 16'd0);
        random_phase(100, 0);
        drain();
        write_reg(CFG_QUANTUM, 16'd2);
        write_reg(CFG_EV_COUNT, 16'd1);
        random_phase(400, 1);
        drain();
        tail_mode = 1;
        write_reg(CFG_EV_COUNT, 16'd3);
        random_phase(300, 1);
        drain();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
